// File: design/htfd_pkg.sv
// Shared types, constants and the CRC-8 helper of the sensor frame decoder.
`default_nettype none

package htfd_pkg;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_KIND_ERR = 2'd1;
  localparam logic [1:0] ST_CRC_ERR  = 2'd2;

  // Expected reading kind carried by the command.
  localparam logic CMD_TEMP = 1'b0;

  // CRC-8, polynomial x^8+x^5+x^4+1, no reflection, no final xor.
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'h00;

  // The two low bits of the second data byte are status bits; bit 1 is the kind.
  localparam logic [7:0] RAW_MASK = 8'hFC;
  localparam int         KIND_BIT = 1;

  // Fixed-point conversion: value = ((scale * raw) >> 16) - offset.
  localparam logic [14:0] T_SCALE  = 15'd17572;
  localparam logic [14:0] H_SCALE  = 15'd12500;
  localparam logic [15:0] T_OFFSET = 16'd4685;
  localparam logic [15:0] H_OFFSET = 16'd600;

  localparam int RAW_W  = 16;
  localparam int PROD_W = 31;
  localparam int VAL_W  = 15;

  typedef logic [RAW_W-1:0]  raw_t;
  typedef logic [PROD_W-1:0] prod_t;
  typedef logic [VAL_W-1:0]  value_t;

  // One byte through the CRC register, MSB first.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: design/humidity_temp_frame_decoder_top.sv
// Top level of the sensor frame decoder: a four-stage checking and conversion pipeline.
`default_nettype none

// The decoder takes one received three-byte sensor frame per word together with
// the expected reading kind, and returns one result word per frame: a status
// (ok, frame of wrong kind, checksum mismatch), the converted reading in
// hundredths of degC or %RH as a signed 15-bit number (zero unless the status is
// ok), and the CRC-8 it computed over the two data bytes. A new frame can be
// accepted in every clock cycle unless a stalled output has filled every stage, so
// the throughput is one word per cycle. A result passes through four register
// stages: the CRC over the first byte, the CRC over the second byte with the kind
// and checksum tests, the 16x15-bit scaling multiply, and the offset and result
// select. Each stage holds its word when the stage behind it is full and stalled,
// so a stalled output only blocks the input once every stage is occupied.
module humidity_temp_frame_decoder_top
  import htfd_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  // Frame input.
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [23:0] in_tdata,   // msb_byte [7:0], lsb_byte [15:8], crc_byte [23:16]
  input  wire  [0:0]  in_tuser,   // command [0]: 0 temperature, 1 humidity
  // Result output.
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [23:0] out_tdata,  // value [14:0], computed_crc [22:15], zero [23]
  output logic [1:0]  out_tuser   // status [1:0]
);

  // Stage valid bits and per-stage ready. A stage may load when it is empty or
  // when the word it holds moves on in the same cycle.
  logic s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r;
  logic s1_ready, s2_ready, s3_ready, s4_ready;

  assign s4_ready  = !s4_valid_r || out_tready;
  assign s3_ready  = !s3_valid_r || s4_ready;
  assign s2_ready  = !s2_valid_r || s3_ready;
  assign s1_ready  = !s1_valid_r || s2_ready;
  assign in_tready = s1_ready;

  // Stage 1: capture the frame and run the CRC over the first data byte.
  logic       s1_cmd_r;
  logic [7:0] s1_msb_r, s1_lsb_r, s1_rcv_r, s1_crc_r;

  // Stage 2: finish the CRC, test kind and checksum, build the raw code.
  logic       s2_cmd_r, s2_kind_ok_r, s2_crc_ok_r;
  logic [7:0] s2_crc_r;
  raw_t       s2_raw_r;

  // Stage 3: scaling product.
  logic       s3_cmd_r;
  logic [1:0] s3_status_r;
  logic [7:0] s3_crc_r;
  prod_t      s3_prod_r;

  // Stage 4: output register.
  logic [1:0] s4_status_r;
  logic [7:0] s4_crc_r;
  value_t     s4_value_r;

  logic [7:0]  s2_crc_nxt;
  logic [1:0]  s3_status_nxt;
  logic [14:0] s3_scale;
  logic [15:0] s4_offset;
  logic [15:0] s4_diff;
  value_t      s4_value_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
      if (s3_ready) begin
        s3_valid_r <= s2_valid_r;
      end
      if (s4_ready) begin
        s4_valid_r <= s3_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_cmd_r <= in_tuser[0];
      s1_msb_r <= in_tdata[7:0];
      s1_lsb_r <= in_tdata[15:8];
      s1_rcv_r <= in_tdata[23:16];
      s1_crc_r <= crc8_update(CRC_INIT, in_tdata[7:0]);
    end
  end

  assign s2_crc_nxt = crc8_update(s1_crc_r, s1_lsb_r);

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_cmd_r     <= s1_cmd_r;
      s2_kind_ok_r <= (s1_lsb_r[KIND_BIT] == s1_cmd_r);
      s2_crc_ok_r  <= (s2_crc_nxt == s1_rcv_r);
      s2_crc_r     <= s2_crc_nxt;
      s2_raw_r     <= {s1_msb_r, s1_lsb_r & RAW_MASK};
    end
  end

  // The kind test takes precedence over the checksum test.
  always_comb begin
    if (!s2_kind_ok_r) begin
      s3_status_nxt = ST_KIND_ERR;
    end else if (!s2_crc_ok_r) begin
      s3_status_nxt = ST_CRC_ERR;
    end else begin
      s3_status_nxt = ST_OK;
    end
  end

  assign s3_scale = (s2_cmd_r == CMD_TEMP) ? T_SCALE : H_SCALE;

  always_ff @(posedge clk) begin
    if (s3_ready) begin
      s3_cmd_r    <= s2_cmd_r;
      s3_status_r <= s3_status_nxt;
      s3_crc_r    <= s2_crc_r;
      s3_prod_r   <= PROD_W'(s2_raw_r) * PROD_W'(s3_scale);
    end
  end

  // Truncating conversion: floor the scaled product, then remove the offset.
  assign s4_offset    = (s3_cmd_r == CMD_TEMP) ? T_OFFSET : H_OFFSET;
  assign s4_diff      = {1'b0, s3_prod_r[PROD_W-1:16]} - s4_offset;
  assign s4_value_nxt = (s3_status_r == ST_OK) ? s4_diff[VAL_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (s4_ready) begin
      s4_status_r <= s3_status_r;
      s4_crc_r    <= s3_crc_r;
      s4_value_r  <= s4_value_nxt;
    end
  end

  assign out_tvalid = s4_valid_r;
  assign out_tdata  = {1'b0, s4_crc_r, s4_value_r};
  assign out_tuser  = s4_status_r;

  // A rejected frame never carries a reading.
  a_err_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ST_OK) |-> (out_tdata[14:0] == '0))
    else $error("rejected frame carries a nonzero value");

  // Only the three defined status codes leave the block.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ST_OK || out_tuser == ST_KIND_ERR ||
                    out_tuser == ST_CRC_ERR))
    else $error("undefined status code on output");

  // An accepted frame always lands in the first stage.
  a_in_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> s1_valid_r)
    else $error("accepted frame lost at stage 1");

  // A word that stage 3 hands forward always lands in the output stage.
  a_s3_to_s4: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_valid_r && s4_ready) |=> s4_valid_r)
    else $error("word lost between stage 3 and output");

  // A stalled output word keeps its status and value.
  a_s4_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s4_valid_r && !out_tready) |=> (s4_valid_r && $stable(s4_status_r) &&
                                     $stable(s4_value_r)))
    else $error("stalled result changed");

endmodule

`default_nettype wire

// File: verif/tb_humidity_temp_frame_decoder_top.sv
// Self-checking testbench that streams sensor frames through the decoder and checks results.
module tb_humidity_temp_frame_decoder_top
  import htfd_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  // The package names only the temperature command, so the other kind gets its own name here.
  localparam logic CMD_HUMID = 1'b1;

  // Cycles without any accepted word before the run is declared hung. The longest quiet
  // stretch in a correct run is the receiver's long hold-off.
  localparam int WATCHDOG_LIMIT = 2000;
  // Cycles to wait after the last expected result, so that a stray extra word would be seen.
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_FRAMES = 370;

  // One decoded result as the decoder should report it.
  typedef struct packed {
    logic [1:0] status;
    value_t     value;
    logic [7:0] crc;
  } decoded_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // msb_byte [7:0], lsb_byte [15:8], crc_byte [23:16]
  logic [0:0]  in_tuser;   // command [0]
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // value [14:0], computed_crc [22:15], zero [23]
  logic [1:0]  out_tuser;  // status [1:0]

  // Results predicted for accepted frames, oldest first.
  decoded_t pending_results[$];

  // Idle shaping shared by the sender, the receiver and the test tasks.
  int tx_max_gap;
  int rx_max_stall;
  int rx_hold_request;

  // Bookkeeping for the summary and the verdict.
  int n_frames;
  int n_ok;
  int n_kind_err;
  int n_crc_err;
  int n_checked;
  int n_errors;
  int n_long_holds;
  int idle_cycles;

  humidity_temp_frame_decoder_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // CRC-8 over the two data bytes, fed one bit at a time with the first byte's MSB first.
  // Shifting the message in bitwise with a zero start value gives the same register as
  // the usual bytewise form.
  function automatic logic [7:0] frame_crc8(input logic [15:0] msg);
    logic [7:0] c;
    logic       feedback;
    c = CRC_INIT;
    for (int i = 15; i >= 0; i--) begin
      feedback = c[7] ^ msg[i];
      c = {c[6:0], 1'b0};
      if (feedback) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  // Full prediction of one frame: the kind test wins over the checksum test, and the
  // reading is only produced when both pass. The product is floored before the offset.
  function automatic decoded_t decode_frame(input logic cmd, input logic [7:0] msb,
                                            input logic [7:0] lsb, input logic [7:0] rcv);
    decoded_t    d;
    int unsigned code;
    int          reading;
    d.crc   = frame_crc8({msb, lsb});
    d.value = '0;
    if (lsb[KIND_BIT] != cmd) begin
      d.status = ST_KIND_ERR;
    end else if (rcv != d.crc) begin
      d.status = ST_CRC_ERR;
    end else begin
      d.status = ST_OK;
      // The two low bits of the second byte are status bits and never part of the code.
      code = {16'd0, msb, lsb & RAW_MASK};
      if (cmd == CMD_TEMP) begin
        reading = int'((code * T_SCALE) >> 16) - int'(T_OFFSET);
      end else begin
        reading = int'((code * H_SCALE) >> 16) - int'(H_OFFSET);
      end
      d.value = value_t'(reading);
    end
    return d;
  endfunction

  // Offers one frame after a random gap and returns once the decoder has taken it.
  // Valid is left high on return so that a back-to-back frame never drops it for a step.
  task automatic send_frame(input logic cmd, input logic [7:0] msb, input logic [7:0] lsb,
                            input logic [7:0] rcv);
    int       gap;
    decoded_t d;
    gap = $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      // Idle cycles carry junk on the data lines, which the decoder must ignore.
      in_tvalid <= 1'b0;
      in_tdata  <= 24'($urandom);
      in_tuser  <= 1'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {rcv, lsb, msb};
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
    d = decode_frame(cmd, msb, lsb, rcv);
    pending_results.push_back(d);
    n_frames++;
    case (d.status)
      ST_OK:       n_ok++;
      ST_KIND_ERR: n_kind_err++;
      default:     n_crc_err++;
    endcase
  endtask

  // Sends a frame whose checksum byte is the correct one.
  task automatic send_good_crc(input logic cmd, input logic [7:0] msb, input logic [7:0] lsb);
    send_frame(cmd, msb, lsb, frame_crc8({msb, lsb}));
  endtask

  // Stops offering words and waits until every predicted result has come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() > 0) @(posedge clk);
  endtask

  // Receiver: random stalls per word, an occasional long hold-off on request, and a
  // field-by-field check of every accepted result against the oldest prediction.
  initial begin : result_checker
    int       stall;
    decoded_t exp_d;
    value_t   got_value;
    logic [7:0] got_crc;
    out_tready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (rx_hold_request > 0) begin
        stall = rx_hold_request;
        rx_hold_request = 0;
        n_long_holds++;
      end else begin
        stall = $urandom_range(0, rx_max_stall);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got_value = out_tdata[14:0];
      got_crc   = out_tdata[22:15];
      if (pending_results.size() == 0) begin
        $display("%0t: result word with no frame waiting: status %0d value %0d crc 0x%02h",
                 $time, out_tuser, $signed(got_value), got_crc);
        n_errors++;
      end else begin
        exp_d = pending_results.pop_front();
        n_checked++;
        if (out_tuser !== exp_d.status) begin
          $display("%0t: status mismatch: expected %0d actual %0d",
                   $time, exp_d.status, out_tuser);
          n_errors++;
        end
        if (got_value !== exp_d.value) begin
          $display("%0t: value mismatch: expected %0d actual %0d",
                   $time, $signed(exp_d.value), $signed(got_value));
          n_errors++;
        end
        if (got_crc !== exp_d.crc) begin
          $display("%0t: computed_crc mismatch: expected 0x%02h actual 0x%02h",
                   $time, exp_d.crc, got_crc);
          n_errors++;
        end
        if (out_tdata[23] !== 1'b0) begin
          $display("%0t: tdata fill bit mismatch: expected 0 actual %b", $time, out_tdata[23]);
          n_errors++;
        end
      end
    end
  end

  // Watchdog: any accepted word on either side resets the count of quiet cycles.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no word accepted for %0d cycles, %0d results still expected",
                 $time, WATCHDOG_LIMIT, pending_results.size());
        $display("tb_humidity_temp_frame_decoder_top failed");
        $finish;
      end
    end
  end

  // The ends of both conversion ranges, the reserved bit, and plain mid-range readings.
  task automatic test_conversion_extremes();
    send_good_crc(CMD_TEMP,  8'h00, 8'h00);  // lowest temperature code
    send_good_crc(CMD_TEMP,  8'hFF, 8'hFD);  // highest temperature code, reserved bit set
    send_good_crc(CMD_TEMP,  8'hFF, 8'hFC);
    send_good_crc(CMD_HUMID, 8'h00, 8'h02);  // lowest humidity code
    send_good_crc(CMD_HUMID, 8'hFF, 8'hFF);  // highest humidity code, reserved bit set
    send_good_crc(CMD_HUMID, 8'hFF, 8'hFE);
    // The reserved bit changes the checksum but not the reading.
    send_good_crc(CMD_TEMP,  8'h66, 8'h64);
    send_good_crc(CMD_TEMP,  8'h66, 8'h65);
    send_good_crc(CMD_HUMID, 8'h63, 8'h52);
    send_good_crc(CMD_HUMID, 8'h63, 8'h53);
    send_good_crc(CMD_TEMP,  8'h80, 8'h00);
    send_good_crc(CMD_HUMID, 8'h7F, 8'hFE);
  endtask

  // Wrong kind in both directions, wrong kind together with a bad checksum, and bad
  // checksums of both kinds including the all-zero and all-one checksum bytes.
  task automatic test_error_frames();
    logic [7:0] good;
    send_good_crc(CMD_TEMP,  8'h5A, 8'h02);
    send_good_crc(CMD_HUMID, 8'hA5, 8'hFD);
    good = frame_crc8({8'h3C, 8'h02});
    send_frame(CMD_TEMP, 8'h3C, 8'h02, good ^ 8'h5A);
    good = frame_crc8({8'hC3, 8'h01});
    send_frame(CMD_HUMID, 8'hC3, 8'h01, good ^ 8'h01);
    good = frame_crc8({8'h12, 8'h34});
    send_frame(CMD_TEMP, 8'h12, 8'h34, good ^ 8'h80);
    good = frame_crc8({8'hED, 8'hCB});
    send_frame(CMD_HUMID, 8'hED, 8'hCB, good ^ 8'h01);
    // The two checksum bytes at the ends of the range; at most one of them can be right.
    send_frame(CMD_TEMP,  8'h00, 8'h01, 8'h00);
    send_frame(CMD_TEMP,  8'h00, 8'h01, 8'hFF);
    send_frame(CMD_HUMID, 8'hFF, 8'hFE, 8'h00);
    send_frame(CMD_HUMID, 8'hFF, 8'hFE, 8'hFF);
  endtask

  // One random frame: mostly well-formed, the rest of the wrong kind or with a bad checksum.
  task automatic send_random_frame();
    int         pick;
    logic       cmd;
    logic [7:0] msb;
    logic [7:0] lsb;
    logic [7:0] good;
    pick = $urandom_range(0, 99);
    cmd  = 1'($urandom);
    msb  = 8'($urandom);
    lsb  = 8'($urandom);
    lsb[KIND_BIT] = cmd;
    if (pick >= 70 && pick < 85) begin
      lsb[KIND_BIT] = ~cmd;
    end
    good = frame_crc8({msb, lsb});
    if (pick >= 85) begin
      send_frame(cmd, msb, lsb, good ^ 8'($urandom_range(1, 255)));
    end else if (pick >= 70 && pick < 78) begin
      // A wrong kind with any checksum byte at all.
      send_frame(cmd, msb, lsb, 8'($urandom));
    end else begin
      send_frame(cmd, msb, lsb, good);
    end
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering frames
  // back to back, so the pipeline fills and the input has to stall.
  task automatic test_output_backpressure();
    tx_max_gap      = 0;
    rx_max_stall    = 0;
    rx_hold_request = 200;
    repeat (40) send_random_frame();
    drain_results();
    tx_max_gap   = 13;
    rx_max_stall = 13;
  endtask

  // The sender stops until the decoder has returned everything, then resumes at full rate.
  task automatic test_sender_pause();
    repeat (10) send_random_frame();
    drain_results();
    tx_max_gap = 0;
    repeat (10) send_random_frame();
    tx_max_gap = 13;
    drain_results();
  endtask

  // Random frames in blocks, each block with its own mix of idling on the two sides,
  // including blocks where neither side ever idles.
  task automatic test_random_frames(input int count);
    int sent;
    int mode;
    sent = 0;
    while (sent < count) begin
      mode = $urandom_range(0, 3);
      tx_max_gap   = (mode == 1 || mode == 3) ? 0 : 13;
      rx_max_stall = (mode == 2 || mode == 3) ? 0 : 13;
      repeat (50) begin
        if (sent < count) begin
          send_random_frame();
          sent++;
        end
      end
    end
    tx_max_gap   = 13;
    rx_max_stall = 13;
  endtask

  initial begin
    rst_n           <= 1'b0;
    in_tvalid       <= 1'b0;
    in_tdata        <= '0;
    in_tuser        <= '0;
    tx_max_gap      = 13;
    rx_max_stall    = 13;
    rx_hold_request = 0;
    n_frames        = 0;
    n_ok            = 0;
    n_kind_err      = 0;
    n_crc_err       = 0;
    n_checked       = 0;
    n_errors        = 0;
    n_long_holds    = 0;
    idle_cycles     = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_conversion_extremes();
    test_error_frames();
    drain_results();
    test_output_backpressure();
    test_sender_pause();
    test_random_frames(RANDOM_FRAMES);

    // Let the pipeline empty out, then wait out the settle time so that any extra word shows.
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d frames and %0d result words: %0d ok, %0d wrong kind, %0d %s",
             n_frames, n_checked, n_ok, n_kind_err, n_crc_err, "bad checksum.");
    $display("Receiver long hold-offs: %0d; %0d mismatches found.", n_long_holds, n_errors);
    if (n_errors == 0) begin
      $display("tb_humidity_temp_frame_decoder_top passed");
    end else begin
      $display("tb_humidity_temp_frame_decoder_top failed");
    end
    $finish;
  end

endmodule
